// ----- rtl/csl_pkg.sv -----
// Shared constants, codes and payload types for the line clip unit.
`default_nettype none

package csl_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int STEP_BITS  = $clog2(DIFF_BITS + 1);
  localparam int PASS_BITS  = 3;

  localparam logic [PASS_BITS-1:0] MAX_PASSES = PASS_BITS'(4);

  // Region code bit positions.
  localparam int RC_LEFT   = 0;
  localparam int RC_RIGHT  = 1;
  localparam int RC_BOTTOM = 2;
  localparam int RC_TOP    = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    CFG_WIN_LEFT   = 2'd0,
    CFG_WIN_BOTTOM = 2'd1,
    CFG_WIN_RIGHT  = 2'd2,
    CFG_WIN_TOP    = 2'd3
  } cfg_index_t;

  localparam coord_t WIN_LEFT_RESET   = COORD_BITS'(-320);
  localparam coord_t WIN_BOTTOM_RESET = COORD_BITS'(-240);
  localparam coord_t WIN_RIGHT_RESET  = COORD_BITS'(319);
  localparam coord_t WIN_TOP_RESET    = COORD_BITS'(239);

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic   accepted;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/cohen_sutherland_line_clip_unit.sv -----
// Cohen-Sutherland line clipper with a shared multiply and restoring divider.
//
// Usage: configure the window through the cfg channel (index 0 left, 1 bottom,
// 2 right, 3 top; always ready), then send one segment per in request. Each
// segment yields exactly one out request: accepted plus the clipped endpoints,
// with all coordinates zero when the segment is rejected.
// Sequence: the segment is loaded, then each pass computes region codes; each
// clipping pass then multiplies, divides bit-serially and fixes up the moved
// endpoint, and the decided result is written into the output register.
// The bit-serial divider, one quotient bit per cycle, computes the edge
// intersection of every pass; a segment gets at most four clipping passes.
// in_ready is high only while no segment is being clipped. The output register
// holds a finished result until out_ready; the next segment is taken meanwhile,
// and the block waits at the end of it if the previous result is still held.
// Reset (synchronous, active high) restores the default window, empties the
// output register and returns the sequencer to idle.
`default_nettype none

module cohen_sutherland_line_clip_unit (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  csl_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output csl_pkg::out_item_t    out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  csl_pkg::cfg_index_t   cfg_index,
  input  csl_pkg::coord_t       cfg_data
);
  import csl_pkg::*;

  localparam int D = DIFF_BITS;
  localparam int R = COORD_BITS + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_CODE, S_MUL, S_DIV, S_FIX, S_DONE
  } state_t;

  state_t                 state;
  coord_t                 win_left, win_bottom, win_right, win_top;
  coord_t                 x1, y1, x2, y2;
  logic [PASS_BITS-1:0]   pass;
  logic                   acc;
  coord_t                 base;
  coord_t                 edge_val;
  logic                   edge_y;
  logic                   move1;
  logic                   neg;
  logic [D-1:0]           mag_a, mag_d, mag_b;
  logic [D-1:0]           rem, lo;
  logic [STEP_BITS-1:0]   step;

  function automatic logic [3:0] region(coord_t x, coord_t y, coord_t l, coord_t b,
                                        coord_t r, coord_t t);
    logic [3:0] c;
    c = 4'b0000;
    c[RC_LEFT]   = (x < l);
    c[RC_RIGHT]  = (x > r);
    c[RC_BOTTOM] = (y < b);
    c[RC_TOP]    = (y > t);
    return c;
  endfunction

  function automatic logic signed [D-1:0] sdiff(coord_t p, coord_t q);
    return $signed({p[COORD_BITS-1], p}) - $signed({q[COORD_BITS-1], q});
  endfunction

  function automatic logic [D-1:0] mag(logic signed [D-1:0] v);
    return v[D-1] ? D'(-v) : D'(v);
  endfunction

  // Region codes and edge selection.
  logic [3:0]             c1, c2, oc;
  logic signed [D-1:0]    op_a, op_d, op_b;
  coord_t                 op_base, op_edge;
  logic                   op_edge_y;

  always_comb begin
    c1 = region(x1, y1, win_left, win_bottom, win_right, win_top);
    c2 = region(x2, y2, win_left, win_bottom, win_right, win_top);
    oc = (c1 != 4'b0000) ? c1 : c2;
    priority if (oc[RC_TOP]) begin
      op_a = sdiff(win_top, y1);
      op_d = sdiff(x2, x1);
      op_b = sdiff(y2, y1);
      op_base = x1;
      op_edge = win_top;
      op_edge_y = 1'b1;
    end else if (oc[RC_BOTTOM]) begin
      op_a = sdiff(win_bottom, y1);
      op_d = sdiff(x2, x1);
      op_b = sdiff(y2, y1);
      op_base = x1;
      op_edge = win_bottom;
      op_edge_y = 1'b1;
    end else if (oc[RC_LEFT]) begin
      op_a = sdiff(win_left, x1);
      op_d = sdiff(y2, y1);
      op_b = sdiff(x2, x1);
      op_base = y1;
      op_edge = win_left;
      op_edge_y = 1'b0;
    end else begin
      op_a = sdiff(win_right, x1);
      op_d = sdiff(y2, y1);
      op_b = sdiff(x2, x1);
      op_base = y1;
      op_edge = win_right;
      op_edge_y = 1'b0;
    end
  end

  // Divider step.
  logic [D:0]   trial;
  logic         ge;
  logic [D:0]   trial_sub;

  always_comb begin
    trial     = {rem, lo[D-1]};
    ge        = (trial >= {1'b0, mag_b});
    trial_sub = trial - {1'b0, mag_b};
  end

  // Intersection fixup: truncate base + a*d/b toward zero.
  logic signed [R-1:0]  base_e, q_e, fl, res;
  logic                 r_nz;
  coord_t               new_val;

  always_comb begin
    base_e = R'(base);
    q_e    = $signed(R'(lo));
    r_nz   = (rem != '0);
    fl     = neg ? base_e - q_e - R'(r_nz) : base_e + q_e;
    if (mag_b == '0 || (lo == '0 && !r_nz)) begin
      res = base_e;
    end else if (r_nz && fl[R-1]) begin
      res = fl + R'(1);
    end else begin
      res = fl;
    end
    new_val = res[COORD_BITS-1:0];
  end

  logic out_free;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      win_left   <= WIN_LEFT_RESET;
      win_bottom <= WIN_BOTTOM_RESET;
      win_right  <= WIN_RIGHT_RESET;
      win_top    <= WIN_TOP_RESET;
      pass       <= '0;
      step       <= '0;
      acc        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WIN_LEFT:   win_left   <= cfg_data;
          CFG_WIN_BOTTOM: win_bottom <= cfg_data;
          CFG_WIN_RIGHT:  win_right  <= cfg_data;
          CFG_WIN_TOP:    win_top    <= cfg_data;
          default:        ;
        endcase
      end

      // Drop the held result unless a new one replaces it this cycle.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x1    <= in_data.start_x;
            y1    <= in_data.start_y;
            x2    <= in_data.end_x;
            y2    <= in_data.end_y;
            pass  <= '0;
            state <= S_CODE;
          end
        end
        S_CODE: begin
          if ((c1 | c2) == 4'b0000) begin
            acc   <= 1'b1;
            state <= S_DONE;
          end else if ((c1 & c2) != 4'b0000 || pass == MAX_PASSES) begin
            acc   <= 1'b0;
            state <= S_DONE;
          end else begin
            mag_a    <= mag(op_a);
            mag_d    <= mag(op_d);
            mag_b    <= mag(op_b);
            neg      <= op_a[D-1] ^ op_d[D-1] ^ op_b[D-1];
            base     <= op_base;
            edge_val <= op_edge;
            edge_y   <= op_edge_y;
            move1    <= (c1 != 4'b0000);
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          {rem, lo} <= PROD_BITS'(mag_a) * PROD_BITS'(mag_d);
          step      <= '0;
          state     <= S_DIV;
        end
        S_DIV: begin
          rem  <= ge ? trial_sub[D-1:0] : trial[D-1:0];
          lo   <= {lo[D-2:0], ge};
          step <= step + STEP_BITS'(1);
          if (step == STEP_BITS'(D - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          // Move the outside endpoint onto the chosen edge.
          if (move1) begin
            x1 <= edge_y ? new_val : edge_val;
            y1 <= edge_y ? edge_val : new_val;
          end else begin
            x2 <= edge_y ? new_val : edge_val;
            y2 <= edge_y ? edge_val : new_val;
          end
          pass  <= pass + PASS_BITS'(1);
          state <= S_CODE;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_valid             <= 1'b1;
            out_data.accepted     <= acc;
            out_data.clip_start_x <= acc ? x1 : '0;
            out_data.clip_start_y <= acc ? y1 : '0;
            out_data.clip_end_x   <= acc ? x2 : '0;
            out_data.clip_end_y   <= acc ? y2 : '0;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/cohen_sutherland_line_clip_unit_tb.sv -----
// Self-checking testbench for the Cohen-Sutherland line clip unit.
module cohen_sutherland_line_clip_unit_tb;
  import csl_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_PCT     = 34;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 100;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int COORD_MIN    = -32768;
  localparam int COORD_MAX    = 32767;

  typedef struct {
    in_item_t  seg;
    out_item_t clip;
  } clip_job_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_WIN_LEFT;
  coord_t     cfg_data = '0;

  // Window as the block should hold it.
  longint win_left   = WIN_LEFT_RESET;
  longint win_bottom = WIN_BOTTOM_RESET;
  longint win_right  = WIN_RIGHT_RESET;
  longint win_top    = WIN_TOP_RESET;

  clip_job_t   pending_clips[$];
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  logic        idle_enable = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  cohen_sutherland_line_clip_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [3:0] region_code(input longint x, input longint y);
    logic [3:0] c;
    c = 4'b0;
    if (x < win_left) c[RC_LEFT] = 1'b1;
    if (x > win_right) c[RC_RIGHT] = 1'b1;
    if (y < win_bottom) c[RC_BOTTOM] = 1'b1;
    if (y > win_top) c[RC_TOP] = 1'b1;
    return c;
  endfunction

  // base + a*d/b, exact, truncated toward zero
  function automatic longint edge_cross(input longint base, input longint a,
                                        input longint d, input longint b);
    if (b == 0) return base;
    return (base * b + a * d) / b;
  endfunction

  function automatic out_item_t predict_clip(input in_item_t seg);
    longint     x1, y1, x2, y2, nx, ny;
    logic [3:0] c1, c2, oc;
    out_item_t  res;
    bit         settled;
    x1 = seg.start_x;
    y1 = seg.start_y;
    x2 = seg.end_x;
    y2 = seg.end_y;
    res = '0;
    settled = 1'b0;
    for (int pass = 0; pass <= int'(MAX_PASSES) && !settled; pass++) begin
      c1 = region_code(x1, y1);
      c2 = region_code(x2, y2);
      if ((c1 | c2) == 4'b0) begin
        res.accepted = 1'b1;
        settled = 1'b1;
      end else if ((c1 & c2) != 4'b0 || pass == int'(MAX_PASSES)) begin
        settled = 1'b1;
      end else begin
        oc = (c1 != 4'b0) ? c1 : c2;
        if (oc[RC_TOP]) begin
          nx = edge_cross(x1, win_top - y1, x2 - x1, y2 - y1);
          ny = win_top;
        end else if (oc[RC_BOTTOM]) begin
          nx = edge_cross(x1, win_bottom - y1, x2 - x1, y2 - y1);
          ny = win_bottom;
        end else if (oc[RC_LEFT]) begin
          ny = edge_cross(y1, win_left - x1, y2 - y1, x2 - x1);
          nx = win_left;
        end else begin
          ny = edge_cross(y1, win_right - x1, y2 - y1, x2 - x1);
          nx = win_right;
        end
        // move the first endpoint that lies outside
        if (c1 != 4'b0) begin
          x1 = nx;
          y1 = ny;
        end else begin
          x2 = nx;
          y2 = ny;
        end
      end
    end
    if (res.accepted) begin
      res.clip_start_x = coord_t'(x1);
      res.clip_start_y = coord_t'(y1);
      res.clip_end_x   = coord_t'(x2);
      res.clip_end_y   = coord_t'(y2);
    end
    return res;
  endfunction

  function automatic string seg_text(input in_item_t seg);
    return $sformatf("(%0d,%0d)-(%0d,%0d)", seg.start_x, seg.start_y,
                     seg.end_x, seg.end_y);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  // Result checker.
  always @(posedge clk) begin : check_clip
    clip_job_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_clips.size() == 0) begin
        report_mismatch("clip result with no segment pending");
      end else begin
        want = pending_clips.pop_front();
        if (out_data.accepted !== want.clip.accepted)
          report_mismatch($sformatf("accepted got %0b want %0b for %s",
            out_data.accepted, want.clip.accepted, seg_text(want.seg)));
        if (out_data.clip_start_x !== want.clip.clip_start_x)
          report_mismatch($sformatf("clip_start_x got %0d want %0d for %s",
            out_data.clip_start_x, want.clip.clip_start_x, seg_text(want.seg)));
        if (out_data.clip_start_y !== want.clip.clip_start_y)
          report_mismatch($sformatf("clip_start_y got %0d want %0d for %s",
            out_data.clip_start_y, want.clip.clip_start_y, seg_text(want.seg)));
        if (out_data.clip_end_x !== want.clip.clip_end_x)
          report_mismatch($sformatf("clip_end_x got %0d want %0d for %s",
            out_data.clip_end_x, want.clip.clip_end_x, seg_text(want.seg)));
        if (out_data.clip_end_y !== want.clip.clip_end_y)
          report_mismatch($sformatf("clip_end_y got %0d want %0d for %s",
            out_data.clip_end_y, want.clip.clip_end_y, seg_text(want.seg)));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_enable && $urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic send_segment(input in_item_t seg);
    clip_job_t job;
    while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= seg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    job.seg  = seg;
    job.clip = predict_clip(seg);
    pending_clips.push_back(job);
  endtask

  task automatic send_points(input int sx, input int sy, input int ex, input int ey);
    in_item_t seg;
    seg.start_x = coord_t'(sx);
    seg.start_y = coord_t'(sy);
    seg.end_x   = coord_t'(ex);
    seg.end_y   = coord_t'(ey);
    send_segment(seg);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input cfg_index_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= coord_t'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_WIN_LEFT:   win_left   = coord_t'(value);
      CFG_WIN_BOTTOM: win_bottom = coord_t'(value);
      CFG_WIN_RIGHT:  win_right  = coord_t'(value);
      CFG_WIN_TOP:    win_top    = coord_t'(value);
    endcase
  endtask

  task automatic set_window(input int left, input int bottom, input int right,
                            input int top);
    wait_idle();
    write_window(CFG_WIN_LEFT, left);
    write_window(CFG_WIN_BOTTOM, bottom);
    write_window(CFG_WIN_RIGHT, right);
    write_window(CFG_WIN_TOP, top);
  endtask

  // Mix of full-range values, window edges and points near the window.
  function automatic int pick_coord(input longint lo, input longint hi);
    longint a, b, v;
    a = ((lo < hi) ? lo : hi) - 40;
    b = ((lo < hi) ? hi : lo) + 40;
    case ($urandom_range(9))
      0, 1, 2: v = coord_t'($urandom());
      3:       v = $urandom_range(1) ? COORD_MAX : COORD_MIN;
      4, 5:    v = ($urandom_range(1) ? lo : hi) + longint'($urandom_range(2)) - 1;
      default: v = a + longint'($urandom_range(int'(b - a)));
    endcase
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return int'(v);
  endfunction

  task automatic send_random_segment();
    send_points(pick_coord(win_left, win_right), pick_coord(win_bottom, win_top),
                pick_coord(win_left, win_right), pick_coord(win_bottom, win_top));
  endtask

  // Reset window: trivial cases, each edge, extremes, corner rejects.
  task automatic test_default_window();
    send_points(0, 0, 100, 50);
    send_points(-1000, 0, -500, 100);
    send_points(0, 0, 0, 1000);
    send_points(10, -1000, 20, 0);
    send_points(-1000, 10, 0, 20);
    send_points(0, 5, 1000, -7);
    send_points(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_points(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_points(-400, 200, -200, 400);
    send_points(5, 5, 5, 5);
    send_points(400, 5, 400, 5);
    send_points(-320, -240, 319, 239);
    send_points(-321, 239, 319, 240);
  endtask

  // Full-range, single-point and inverted windows.
  task automatic test_edge_windows();
    set_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_points(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    send_points(-1, -1, 0, 0);
    set_window(0, 0, 0, 0);
    send_points(-5, -5, 5, 5);
    send_points(-5, 3, 5, 4);
    // inverted in x: shared outside codes reject both segments
    set_window(100, -50, -100, 50);
    send_points(0, 0, 10, 10);
    send_points(-200, 0, 200, 10);
    // inverted in y
    set_window(-100, 60, 100, -60);
    send_points(0, -200, 5, 200);
    send_points(0, 0, 0, 0);
  endtask

  task automatic test_random_clips();
    int lx, hx, ly, hy, t;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_window(WIN_LEFT_RESET, WIN_BOTTOM_RESET, WIN_RIGHT_RESET, WIN_TOP_RESET);
        1: set_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        2: set_window(32000, COORD_MIN, COORD_MAX, -32000);
        default: begin
          lx = coord_t'($urandom());
          ly = coord_t'($urandom());
          if (phase % 2 == 1) begin
            hx = lx + $urandom_range(800);
            hy = ly + $urandom_range(800);
            if (hx > COORD_MAX) hx = COORD_MAX;
            if (hy > COORD_MAX) hy = COORD_MAX;
          end else begin
            hx = coord_t'($urandom());
            hy = coord_t'($urandom());
          end
          if (hx < lx) begin
            t = hx; hx = lx; lx = t;
          end
          if (hy < ly) begin
            t = hy; hy = ly; ly = t;
          end
          // last phase: swap the edges to invert the window
          if (phase == 7) set_window(hx, hy, lx, ly);
          else set_window(lx, ly, hx, hy);
        end
      endcase
      repeat (40) send_random_segment();
    end
  endtask

  task automatic test_no_idle_burst();
    set_window(-1000, -800, 1200, 900);
    idle_enable <= 1'b0;
    repeat (60) send_random_segment();
    wait_idle();
    idle_enable <= 1'b1;
    @(posedge clk);
  endtask

  // Hold off the receiver while segments keep coming so the input stalls.
  task automatic test_output_hold_off();
    set_window(WIN_LEFT_RESET, WIN_BOTTOM_RESET, WIN_RIGHT_RESET, WIN_TOP_RESET);
    hold_requests <= hold_requests + 1;
    @(posedge clk);
    repeat (10) send_points(coord_t'($urandom_range(200)), coord_t'($urandom_range(200)),
                            -100, 0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_window();
    test_edge_windows();
    test_random_clips();
    test_no_idle_burst();
    test_output_hold_off();
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_clips.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
